FILE: rtl/core/ptfp_pkg.sv
// shared types and constants for the pixel to floor position block
package ptfp_pkg;

  localparam int ANG_W = 16;
  localparam logic [15:0] DEG90 = 16'd23040;
  localparam logic [15:0] DEG85 = 16'd21760;
  localparam logic [15:0] DEG180 = 16'd46080;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam int ATAN_COUNT = 24;
  localparam int CW = 34;
  localparam int ZW = 30;

  // register indexes
  localparam logic [2:0] REG_CENTER_COL = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW = 3'd1;
  localparam logic [2:0] REG_DPP_H = 3'd2;
  localparam logic [2:0] REG_DPP_V = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = 30'sd47185920;  1: r = 30'sd27855475;  2: r = 30'sd14718068;
        3: r = 30'sd7471121;   4: r = 30'sd3750058;   5: r = 30'sd1876857;
        6: r = 30'sd938658;    7: r = 30'sd469357;    8: r = 30'sd234682;
        9: r = 30'sd117342;    10: r = 30'sd58671;    11: r = 30'sd29335;
        12: r = 30'sd14668;    13: r = 30'sd7334;     14: r = 30'sd3667;
        15: r = 30'sd1833;     16: r = 30'sd917;      17: r = 30'sd458;
        18: r = 30'sd229;      19: r = 30'sd115;      20: r = 30'sd57;
        21: r = 30'sd29;       22: r = 30'sd14;       23: r = 30'sd7;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // item handed from front to back
  typedef struct packed {
    logic [15:0] polar;
    logic [15:0] az;
    logic signed [15:0] z;
    logic last;
  } ang_item_t;

endpackage

FILE: rtl/core/ptfp_front.sv
// front: pixel offset to clamped Q8.8 angles, one item per cycle
module ptfp_front import ptfp_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [PIXEL_BITS-1:0] pixel_col,
  input  logic [PIXEL_BITS-1:0] pixel_row,
  input  logic frame_last,
  input  logic [PIXEL_BITS-1:0] center_col,
  input  logic [PIXEL_BITS-1:0] center_row,
  input  logic [15:0] deg_per_px_h,
  input  logic [15:0] deg_per_px_v,
  input  logic signed [15:0] height_offset,
  output logic out_valid,
  output ang_item_t out_item
);
  localparam int PW = PIXEL_BITS + 16;

  logic s1_valid;
  logic s1_neg_v, s1_neg_h, s1_last;
  logic [PW-1:0] s1_pv, s1_ph;
  logic signed [15:0] s1_z;
  logic [PIXEL_BITS-1:0] dv, dh;
  logic [PW-8:0] mv, mh;
  logic signed [PW-6:0] pol_raw, az_raw;
  logic [15:0] pol_c, az_c;

  // pixel distance magnitudes
  always_comb begin
    dv = (pixel_row < center_row) ? center_row - pixel_row : pixel_row - center_row;
    dh = (pixel_col < center_col) ? center_col - pixel_col : pixel_col - center_col;
  end

  // stage 1: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_pv <= PW'(dv) * PW'(deg_per_px_v);
    s1_ph <= PW'(dh) * PW'(deg_per_px_h);
    s1_neg_v <= pixel_row < center_row;
    s1_neg_h <= pixel_col < center_col;
    s1_last <= frame_last;
    s1_z <= height_offset;
  end

  // round, apply sign and clamp; a polar angle of exactly 90 degrees becomes 85
  always_comb begin
    mv = (PW-7)'((PW+1)'(s1_pv) + (PW+1)'(128) >> 8);
    mh = (PW-7)'((PW+1)'(s1_ph) + (PW+1)'(128) >> 8);
    pol_raw = s1_neg_v ? $signed((PW-5)'(DEG90)) - $signed({1'b0, mv})
                       : $signed((PW-5)'(DEG90)) + $signed({1'b0, mv});
    az_raw = s1_neg_h ? $signed((PW-5)'(DEG90)) + $signed({1'b0, mh})
                      : $signed((PW-5)'(DEG90)) - $signed({1'b0, mh});
    if (pol_raw < 0) pol_c = '0;
    else if (pol_raw > $signed((PW-5)'(DEG180))) pol_c = DEG180;
    else pol_c = pol_raw[15:0];
    if (pol_c == DEG90) pol_c = DEG85;
    if (az_raw < 0) az_c = '0;
    else if (az_raw > $signed((PW-5)'(DEG180))) az_c = DEG180;
    else az_c = az_raw[15:0];
  end

  // stage 2: registered item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    out_item.polar <= pol_c;
    out_item.az <= az_c;
    out_item.z <= s1_z;
    out_item.last <= s1_last;
  end
endmodule

FILE: rtl/core/ptfp_fifo.sv
// short queue between front and back
module ptfp_fifo import ptfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  ang_item_t wr_item,
  input  logic rd_en,
  output logic rd_valid,
  output ang_item_t rd_item
);
  ang_item_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign rd_valid = count != 3'd0;
  assign rd_item = mem[rp];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= wp + 2'd1;
      if (rd_en && rd_valid) rp <= rp + 2'd1;
      count <= count + 3'(wr_en) - 3'(rd_en && rd_valid);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 3'd4 |-> !wr_en || rd_en) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count[1:0] == wp - rp) else $error("queue pointers disagree with count");
endmodule

FILE: rtl/core/ptfp_back.sv
// back: cordic sin/cos, projection and pipelined division
module ptfp_back import ptfp_pkg::*; #(
  parameter int TRIG_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  ang_item_t in_item,
  output logic done,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [15:0] polar_deg,
  output logic [15:0] azimuth_deg,
  output logic clipped,
  output logic frame_end
);
  localparam int NS = (TRIG_STAGES < ATAN_COUNT) ? TRIG_STAGES : ATAN_COUNT;
  localparam int NW = 48;   // |num| < 2^46
  localparam int DW = 32;   // 2*|cos| < 2^32
  localparam int QW = 24;   // quotient bits kept before saturation

  // cordic pipeline, two lanes (polar, azimuth)
  logic signed [CW-1:0] px [NS+1];
  logic signed [CW-1:0] py [NS+1];
  logic signed [ZW-1:0] pz [NS+1];
  logic signed [CW-1:0] ax [NS+1];
  logic signed [CW-1:0] ay [NS+1];
  logic signed [ZW-1:0] az [NS+1];
  ang_item_t it [NS+1];
  logic vld [NS+1];

  always_comb begin
    px[0] = GAIN_Q30;
    py[0] = '0;
    pz[0] = ZW'(($signed({1'b0, in_item.polar}) - $signed({1'b0, DEG90})) * 4096);
    ax[0] = GAIN_Q30;
    ay[0] = '0;
    az[0] = ZW'(($signed({1'b0, in_item.az}) - $signed({1'b0, DEG90})) * 4096);
    it[0] = in_item;
    vld[0] = in_valid;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      it[i+1] <= it[i];
      if (!pz[i][ZW-1]) begin
        px[i+1] <= px[i] - (py[i] >>> i);
        py[i+1] <= py[i] + (px[i] >>> i);
        pz[i+1] <= pz[i] - atan_lut(i);
      end else begin
        px[i+1] <= px[i] + (py[i] >>> i);
        py[i+1] <= py[i] - (px[i] >>> i);
        pz[i+1] <= pz[i] + atan_lut(i);
      end
      if (!az[i][ZW-1]) begin
        ax[i+1] <= ax[i] - (ay[i] >>> i);
        ay[i+1] <= ay[i] + (ax[i] >>> i);
        az[i+1] <= az[i] - atan_lut(i);
      end else begin
        ax[i+1] <= ax[i] + (ay[i] >>> i);
        ay[i+1] <= ay[i] - (ax[i] >>> i);
        az[i+1] <= az[i] + atan_lut(i);
      end
    end
  end

  // trig results: cos(a) = -y, sin(a) = x
  logic signed [CW-1:0] cp, sp, ca, sa;
  assign cp = -py[NS];
  assign sp = px[NS];
  assign ca = -ay[NS];
  assign sa = ax[NS];

  // m1: magnitude products sp*trig
  logic m1_v;
  ang_item_t m1_it;
  logic m1_nx, m1_ny, m1_ncp;
  logic [65:0] m1_px, m1_py;
  logic [CW-1:0] m1_mcp;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else m1_v <= vld[NS];
    m1_it <= it[NS];
    m1_px <= 66'(mag(sp)) * 66'(mag(ca));
    m1_py <= 66'(mag(sp)) * 66'(mag(sa));
    m1_nx <= sp[CW-1] ^ ca[CW-1];
    m1_ny <= sp[CW-1] ^ sa[CW-1];
    m1_mcp <= mag(cp);
    m1_ncp <= cp[CW-1];
  end

  // m2: round to Q30, times |z|
  logic m2_v;
  ang_item_t m2_it;
  logic m2_nx, m2_ny, m2_ncp;
  logic [NW-1:0] m2_nmx, m2_nmy;
  logic [CW-1:0] m2_mcp;
  logic [31:0] sx, sy;
  logic [15:0] zm;

  always_comb begin
    sx = 32'((m1_px + 66'd536870912) >> 30);
    sy = 32'((m1_py + 66'd536870912) >> 30);
    zm = m1_it.z[15] ? 16'(-m1_it.z) : 16'(m1_it.z);
  end

  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else m2_v <= m1_v;
    m2_it <= m1_it;
    m2_nmx <= NW'(sx) * NW'(zm);
    m2_nmy <= NW'(sy) * NW'(zm);
    m2_nx <= m1_nx ^ m1_it.z[15];
    m2_ny <= m1_ny ^ m1_it.z[15];
    m2_mcp <= m1_mcp;
    m2_ncp <= m1_ncp;
  end

  // divider lanes: q = (2n + c) / (2c), restoring, one quotient bit per stage
  localparam int DV = QW + 1;
  localparam int RW = DW + DV + 1;  // room for 2c shifted by the quotient width
  logic [RW-1:0] dnx [DV+1];
  logic [RW-1:0] dny [DV+1];
  logic [QW:0] qx [DV+1];
  logic [QW:0] qy [DV+1];
  logic [DW-1:0] dd [DV+1];
  logic dnzx [DV+1];
  logic dnzy [DV+1];
  logic sgx [DV+1];
  logic sgy [DV+1];
  logic czero [DV+1];
  ang_item_t dit [DV+1];
  logic dvl [DV+1];
  // overflow flag carried beside: quotient saturation if (2n + c) / (2c) too large
  logic ovx [DV+1];
  logic ovy [DV+1];

  logic [RW-1:0] nx0, ny0;
  logic [DW-1:0] d0;
  logic [RW-1:0] lim;

  always_comb begin
    d0 = DW'({m2_mcp, 1'b0});
    nx0 = RW'({m2_nmx, 1'b0}) + RW'(m2_mcp);
    ny0 = RW'({m2_nmy, 1'b0}) + RW'(m2_mcp);
    lim = RW'(d0) << DV;
    dnx[0] = nx0;
    dny[0] = ny0;
    qx[0] = '0;
    qy[0] = '0;
    dd[0] = d0;
    dnzx[0] = m2_nmx != '0;
    dnzy[0] = m2_nmy != '0;
    sgx[0] = m2_nx ^ m2_ncp;
    sgy[0] = m2_ny ^ m2_ncp;
    czero[0] = m2_mcp == '0;
    dit[0] = m2_it;
    dvl[0] = m2_v;
    ovx[0] = (czero[0] == 1'b0) && (nx0 >= lim);
    ovy[0] = (czero[0] == 1'b0) && (ny0 >= lim);
  end

  for (genvar k = 0; k < DV; k++) begin : g_div
    localparam int SH = DV - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) dvl[k+1] <= 1'b0;
      else dvl[k+1] <= dvl[k];
      dd[k+1] <= dd[k];
      dnzx[k+1] <= dnzx[k];
      dnzy[k+1] <= dnzy[k];
      sgx[k+1] <= sgx[k];
      sgy[k+1] <= sgy[k];
      czero[k+1] <= czero[k];
      dit[k+1] <= dit[k];
      ovx[k+1] <= ovx[k];
      ovy[k+1] <= ovy[k];
      if (dnx[k] >= (RW'(dd[k]) << SH)) begin
        dnx[k+1] <= dnx[k] - (RW'(dd[k]) << SH);
        qx[k+1] <= qx[k] | ((QW+1)'(1) << SH);
      end else begin
        dnx[k+1] <= dnx[k];
        qx[k+1] <= qx[k];
      end
      if (dny[k] >= (RW'(dd[k]) << SH)) begin
        dny[k+1] <= dny[k] - (RW'(dd[k]) << SH);
        qy[k+1] <= qy[k] | ((QW+1)'(1) << SH);
      end else begin
        dny[k+1] <= dny[k];
        qy[k+1] <= qy[k];
      end
    end
  end

  // final sign, saturation and output register
  logic signed [23:0] fx, fy;
  logic clx, cly;

  function automatic logic [24:0] sat_fn(input logic [QW:0] q, input logic ov,
                                         input logic neg, input logic nz,
                                         input logic cz);
    logic [23:0] r;
    logic c;
    begin
      c = 1'b0;
      if (!nz) begin
        r = '0;
      end else if (cz) begin
        r = neg ? 24'h800000 : 24'h7FFFFF;
        c = 1'b1;
      end else if (neg) begin
        if (ov || q > 25'd8388608) begin
          r = 24'h800000;
          c = 1'b1;
        end else begin
          r = 24'(-q);
        end
      end else begin
        if (ov || q > 25'd8388607) begin
          r = 24'h7FFFFF;
          c = 1'b1;
        end else begin
          r = q[23:0];
        end
      end
      return {c, r};
    end
  endfunction

  always_comb begin
    // with zero cosine the sign follows num alone; num sign is sg xor cp sign (cp=0)
    {clx, fx} = sat_fn(qx[DV], ovx[DV], sgx[DV], dnzx[DV], czero[DV]);
    {cly, fy} = sat_fn(qy[DV], ovy[DV], sgy[DV], dnzy[DV], czero[DV]);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dvl[DV];
    pos_x <= fx;
    pos_y <= fy;
    pos_z <= dit[DV].z;
    polar_deg <= dit[DV].polar;
    azimuth_deg <= dit[DV].az;
    clipped <= clx | cly;
    frame_end <= dit[DV].last;
  end

  a_clip_on_zero_cos: assert property (@(posedge clk) disable iff (rst)
    dvl[DV] && czero[DV] && dnzx[DV] |=> clipped) else $error("zero cosine not clipped");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    dvl[DV] |=> done) else $error("result lost");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> polar_deg <= DEG180 && azimuth_deg <= DEG180 && polar_deg != DEG90)
    else $error("angle out of range");
endmodule

FILE: rtl/core/pixel_to_floor_position.sv
// top level: register port, front, queue and back of the floor position block
//
// Usage: pulse start with pixel_col, pixel_row and frame_last while busy is
// low; busy never rises, so one point is taken every cycle. Each point gives
// exactly one result, shown for one cycle with done high on pos_x, pos_y,
// pos_z, polar_deg, azimuth_deg, clipped and frame_end.
// Pipeline: front stages 1 and 2 of angle arithmetic, the queue register,
// TRIG_STAGES cordic stages, 2 multiply stages, 25 divider stages and the
// output register.
// Throughput is one point per cycle, set by the fully pipelined cordic and
// divider lanes.
// Registers are written over the APB port (byte addresses 0,4,8,12,16); the
// user must write them only while no point is in flight; the block does not
// enforce it. Reads return the stored values. Reset (rst, synchronous)
// restores the register defaults and empties all stages. The receiver cannot
// stall: results are presented once and must be taken in that cycle.
module pixel_to_floor_position import ptfp_pkg::*; #(
  parameter int PIXEL_BITS = 12,
  parameter int TRIG_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic start,
  output logic busy,
  input  logic [PIXEL_BITS-1:0] pixel_col,
  input  logic [PIXEL_BITS-1:0] pixel_row,
  input  logic frame_last,
  output logic done,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [15:0] polar_deg,
  output logic [15:0] azimuth_deg,
  output logic clipped,
  output logic frame_end
);
  logic [PIXEL_BITS-1:0] center_col, center_row;
  logic [15:0] deg_per_px_h, deg_per_px_v;
  logic signed [15:0] height_offset;
  logic [2:0] idx;
  logic fr_valid, q_valid;
  ang_item_t fr_item, q_item;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign idx = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= PIXEL_BITS'(320);
      center_row <= PIXEL_BITS'(240);
      deg_per_px_h <= 16'd5069;
      deg_per_px_v <= 16'd5069;
      height_offset <= 16'sd1400;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_CENTER_COL: center_col <= pwdata[PIXEL_BITS-1:0];
        REG_CENTER_ROW: center_row <= pwdata[PIXEL_BITS-1:0];
        REG_DPP_H: deg_per_px_h <= pwdata[15:0];
        REG_DPP_V: deg_per_px_v <= pwdata[15:0];
        REG_HEIGHT: height_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (idx)
      REG_CENTER_COL: prdata = 32'(center_col);
      REG_CENTER_ROW: prdata = 32'(center_row);
      REG_DPP_H: prdata = 32'(deg_per_px_h);
      REG_DPP_V: prdata = 32'(deg_per_px_v);
      REG_HEIGHT: prdata = 32'(height_offset);
      default: prdata = '0;
    endcase
  end

  ptfp_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst, .in_valid(start), .pixel_col, .pixel_row, .frame_last,
    .center_col, .center_row, .deg_per_px_h, .deg_per_px_v, .height_offset,
    .out_valid(fr_valid), .out_item(fr_item)
  );

  ptfp_fifo u_fifo (
    .clk, .rst, .wr_en(fr_valid), .wr_item(fr_item), .rd_en(1'b1),
    .rd_valid(q_valid), .rd_item(q_item)
  );

  ptfp_back #(.TRIG_STAGES(TRIG_STAGES)) u_back (
    .clk, .rst, .in_valid(q_valid), .in_item(q_item), .done,
    .pos_x, .pos_y, .pos_z, .polar_deg, .azimuth_deg, .clipped, .frame_end
  );
endmodule
